// ----- hw/rtl/eip_pkg.sv -----
`timescale 1ns / 1ps

package eip_pkg;

  // Fixed port widths of the request and result channels
  localparam int unsigned ActionW    = 3;
  localparam int unsigned IdInW      = 8;
  localparam int unsigned MaskIoW    = 32;
  localparam int unsigned ResultIdW  = 7;
  localparam int unsigned CountOutW  = 8;

  typedef enum logic [ActionW-1:0] {
    ACT_CREATE   = 3'd0,
    ACT_DESTROY  = 3'd1,
    ACT_SET_MASK = 3'd2,
    ACT_GET_MASK = 3'd3,
    ACT_READ     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    RESP_FAIL,
    RESP_OK,
    RESP_ALLOC,
    RESP_MASK,
    RESP_ENTRY
  } resp_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CR_COMMIT,
    ST_DS_CHECK,
    ST_DS_MOVE,
    ST_DS_FREE,
    ST_RD_WAIT
  } state_e;

  typedef struct packed {
    logic  clr_step;
    logic  load_req;
    logic  rd_fifo;
    logic  rd_meta;
    logic  rd_list_last;
    logic  rd_list_idx;
    logic  rd_mask;
    logic  wr_mask_zero;
    logic  wr_mask_set;
    logic  alloc;
    logic  move;
    logic  free;
    logic  respond;
    resp_e resp;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    clear_last;
    logic    full;
    logic    empty;
    logic    in_range;
    logic    idx_ok;
    logic    living;
    logic    slot_free;
  } stat_t;

endpackage

// ----- hw/rtl/eip_dpath.sv -----
`timescale 1ns / 1ps

module eip_dpath import eip_pkg::*; #(
  parameter int unsigned ID_COUNT  = 128,
  parameter int unsigned MASK_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ActionW-1:0]   action_i,
  input  logic [IdInW-1:0]     entity_id_i,
  input  logic [MaskIoW-1:0]   mask_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 ok_o,
  output logic [ResultIdW-1:0] result_id_o,
  output logic [MaskIoW-1:0]   mask_out_o,
  output logic [CountOutW-1:0] living_count_o,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o
);

  localparam int unsigned IDW  = $clog2(ID_COUNT);
  localparam int unsigned CNTW = $clog2(ID_COUNT + 1);
  localparam logic [IDW-1:0] LastId = IDW'(ID_COUNT - 1);

  // Request registers
  action_e          req_action_q;
  logic [IdInW-1:0] req_id_q;
  logic [MaskIoW-1:0] req_mask_q;
  logic [IDW-1:0]   req_idx;

  // Pointers and counters
  logic [IDW-1:0]  head_q, tail_q, clr_q;
  logic            wrapped_q;
  logic [CNTW-1:0] total_q, total_d;

  // Memories and their read registers
  logic [IDW-1:0]       fifo_mem [ID_COUNT];
  logic [IDW-1:0]       list_mem [ID_COUNT];
  logic [IDW:0]         meta_mem [ID_COUNT];
  logic [MASK_BITS-1:0] mask_mem [ID_COUNT];

  logic [IDW-1:0]       fifo_rd_q, head_copy_q, list_rd_q;
  logic                 fifo_pristine_q;
  logic [IDW:0]         meta_rd_q;
  logic [MASK_BITS-1:0] mask_rd_q;

  logic [IDW-1:0] nid;

  logic                 meta_we, list_we, list_re, mask_we;
  logic [IDW-1:0]       meta_wa, list_wa, list_ra, mask_wa;
  logic [IDW:0]         meta_wd;
  logic [IDW-1:0]       list_wd;
  logic [MASK_BITS-1:0] mask_wd;

  logic                 out_valid_q, ok_q;
  logic [ResultIdW-1:0] rid_q;
  logic [MaskIoW-1:0]   mout_q;
  logic [CountOutW-1:0] cnt_q;
  logic                 slot_free;

  function automatic logic [IDW-1:0] next_ptr(input logic [IDW-1:0] p);
    return (p == LastId) ? '0 : p + IDW'(1);
  endfunction

  assign req_idx = IDW'(req_id_q);
  // An entry the free list never wrote still holds its own index
  assign nid = fifo_pristine_q ? head_copy_q : fifo_rd_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    total_d = total_q;
    if (cmd_i.alloc) begin
      total_d = total_q + CNTW'(1);
    end else if (cmd_i.free) begin
      total_d = total_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_action_q <= action_e'(action_i);
      req_id_q     <= entity_id_i;
      req_mask_q   <= mask_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      clr_q     <= '0;
      wrapped_q <= 1'b0;
      total_q   <= '0;
    end else begin
      total_q <= total_d;
      if (cmd_i.clr_step) begin
        clr_q <= next_ptr(clr_q);
      end
      if (cmd_i.alloc) begin
        head_q <= next_ptr(head_q);
      end
      if (cmd_i.free) begin
        tail_q <= next_ptr(tail_q);
        if (tail_q == LastId) begin
          wrapped_q <= 1'b1;
        end
      end
    end
  end

  // Free list: written only on release, read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.free) begin
      fifo_mem[tail_q] <= req_idx;
    end
    if (cmd_i.rd_fifo) begin
      fifo_rd_q       <= fifo_mem[head_q];
      head_copy_q     <= head_q;
      fifo_pristine_q <= !wrapped_q && (head_q >= tail_q);
    end
  end

  // Living list
  always_comb begin
    list_we = cmd_i.alloc || cmd_i.move;
    list_wa = cmd_i.alloc ? IDW'(total_q) : meta_rd_q[IDW-1:0];
    list_wd = cmd_i.alloc ? nid : list_rd_q;
    list_re = cmd_i.rd_list_last || cmd_i.rd_list_idx;
    list_ra = cmd_i.rd_list_last ? IDW'(total_q - CNTW'(1)) : req_idx;
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_ra];
    end
  end

  // Reverse index: living bit and slot per ID
  always_comb begin
    meta_we = 1'b1;
    meta_wa = req_idx;
    meta_wd = '0;
    if (cmd_i.clr_step) begin
      meta_wa = clr_q;
    end else if (cmd_i.alloc) begin
      meta_wa = nid;
      meta_wd = {1'b1, IDW'(total_q)};
    end else if (cmd_i.move) begin
      meta_wa = list_rd_q;
      meta_wd = {1'b1, meta_rd_q[IDW-1:0]};
    end else if (!cmd_i.free) begin
      meta_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (cmd_i.rd_meta) begin
      meta_rd_q <= meta_mem[req_idx];
    end
  end

  // Mask table
  always_comb begin
    mask_we = cmd_i.clr_step || cmd_i.wr_mask_zero || cmd_i.wr_mask_set;
    mask_wa = cmd_i.clr_step ? clr_q : req_idx;
    mask_wd = cmd_i.wr_mask_set ? MASK_BITS'(req_mask_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_wa] <= mask_wd;
    end
    if (cmd_i.rd_mask) begin
      mask_rd_q <= mask_mem[req_idx];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      ok_q   <= 1'b1;
      rid_q  <= '0;
      mout_q <= '0;
      cnt_q  <= CountOutW'(total_d);
      case (cmd_i.resp)
        RESP_OK:    ;
        RESP_ALLOC: rid_q  <= ResultIdW'(nid);
        RESP_MASK:  mout_q <= MaskIoW'(mask_rd_q);
        RESP_ENTRY: rid_q  <= ResultIdW'(list_rd_q);
        default:    ok_q   <= 1'b0;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign result_id_o    = rid_q;
  assign mask_out_o     = mout_q;
  assign living_count_o = cnt_q;

  always_comb begin
    stat_o.action     = req_action_q;
    stat_o.clear_last = (clr_q == LastId);
    stat_o.full       = (total_q == CNTW'(ID_COUNT));
    stat_o.empty      = (total_q == '0);
    stat_o.in_range   = 32'(req_id_q) < 32'(ID_COUNT);
    stat_o.idx_ok     = 32'(req_id_q) < 32'(total_q);
    stat_o.living     = meta_rd_q[IDW];
    stat_o.slot_free  = slot_free;
  end

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= 32'(ID_COUNT))
    else $error("living count beyond pool size");

  a_respond_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.respond |-> slot_free)
    else $error("result written over a waiting result");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |-> (total_q != CNTW'(ID_COUNT)))
    else $error("allocation from an exhausted pool");

  a_free_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free |-> (total_q != '0) && meta_rd_q[IDW])
    else $error("release of an ID that is not living");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((total_q == '0) || (total_q == CNTW'(ID_COUNT))) |-> (head_q == tail_q))
    else $error("free list pointers out of step with living count");
`endif

endmodule

// ----- hw/rtl/eip_ctrl.sv -----
`timescale 1ns / 1ps

module eip_ctrl import eip_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat_i.action)
          ACT_CREATE: begin
            if (!stat_i.full) begin
              cmd_o.rd_fifo = 1'b1;
              state_d       = ST_CR_COMMIT;
            end else if (stat_i.slot_free) begin
              cmd_o.respond = 1'b1;
              cmd_o.resp    = RESP_FAIL;
              state_d       = ST_IDLE;
            end
          end
          ACT_DESTROY: begin
            if (stat_i.in_range && !stat_i.empty) begin
              cmd_o.wr_mask_zero = 1'b1;
              cmd_o.rd_meta      = 1'b1;
              state_d            = ST_DS_CHECK;
            end else if (stat_i.slot_free) begin
              cmd_o.respond = 1'b1;
              cmd_o.resp    = RESP_FAIL;
              state_d       = ST_IDLE;
            end
          end
          ACT_SET_MASK: begin
            if (stat_i.slot_free) begin
              cmd_o.wr_mask_set = stat_i.in_range;
              cmd_o.respond     = 1'b1;
              cmd_o.resp        = stat_i.in_range ? RESP_OK : RESP_FAIL;
              state_d           = ST_IDLE;
            end
          end
          ACT_GET_MASK: begin
            if (stat_i.in_range) begin
              cmd_o.rd_mask = 1'b1;
              state_d       = ST_RD_WAIT;
            end else if (stat_i.slot_free) begin
              cmd_o.respond = 1'b1;
              cmd_o.resp    = RESP_FAIL;
              state_d       = ST_IDLE;
            end
          end
          ACT_READ: begin
            if (stat_i.idx_ok) begin
              cmd_o.rd_list_idx = 1'b1;
              state_d           = ST_RD_WAIT;
            end else if (stat_i.slot_free) begin
              cmd_o.respond = 1'b1;
              cmd_o.resp    = RESP_FAIL;
              state_d       = ST_IDLE;
            end
          end
          default: begin
            if (stat_i.slot_free) begin
              cmd_o.respond = 1'b1;
              cmd_o.resp    = RESP_FAIL;
              state_d       = ST_IDLE;
            end
          end
        endcase
      end
      ST_CR_COMMIT: begin
        if (stat_i.slot_free) begin
          cmd_o.alloc   = 1'b1;
          cmd_o.respond = 1'b1;
          cmd_o.resp    = RESP_ALLOC;
          state_d       = ST_IDLE;
        end
      end
      ST_DS_CHECK: begin
        if (stat_i.living) begin
          cmd_o.rd_list_last = 1'b1;
          state_d            = ST_DS_MOVE;
        end else if (stat_i.slot_free) begin
          // mask already cleared; nothing else changes
          cmd_o.respond = 1'b1;
          cmd_o.resp    = RESP_FAIL;
          state_d       = ST_IDLE;
        end
      end
      ST_DS_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_DS_FREE;
      end
      ST_DS_FREE: begin
        if (stat_i.slot_free) begin
          cmd_o.free    = 1'b1;
          cmd_o.respond = 1'b1;
          cmd_o.resp    = RESP_OK;
          state_d       = ST_IDLE;
        end
      end
      ST_RD_WAIT: begin
        if (stat_i.slot_free) begin
          cmd_o.respond = 1'b1;
          cmd_o.resp    = (stat_i.action == ACT_GET_MASK) ? RESP_MASK : RESP_ENTRY;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/entity_id_pool_with_masks.sv -----
`timescale 1ns / 1ps

// ID pool with one component mask per ID.
// Request channel: in_valid_i / in_stall_o carry action_i, entity_id_i and
// mask_in_i. Actions: create, destroy, set mask, get mask, read living entry.
// Result channel: out_valid_o / out_stall_i carry ok_o, result_id_o,
// mask_out_o and living_count_o; every request yields exactly one result.
// A request is taken in the cycle it is seen in idle, so requests are served
// one at a time. The free list, living list, reverse index and mask table
// are single-port memories with registered read data; the destroy
// swap-remove reads the reverse index, then the last living-list entry,
// then writes the moved entry and finally frees the ID.
// After reset the reverse index and the mask table are swept clear, one
// entry per cycle, while requests are stalled.
// The result register parts the two sides: a new request is taken while a
// result waits, but its result is held back until the receiver drops stall.

module entity_id_pool_with_masks import eip_pkg::*; #(
  parameter int unsigned ID_COUNT  = 128,
  parameter int unsigned MASK_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ActionW-1:0]   action_i,
  input  logic [IdInW-1:0]     entity_id_i,
  input  logic [MaskIoW-1:0]   mask_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 ok_o,
  output logic [ResultIdW-1:0] result_id_o,
  output logic [MaskIoW-1:0]   mask_out_o,
  output logic [CountOutW-1:0] living_count_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request through the memories
  eip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the free list, living list, reverse index, masks and result
  eip_dpath #(
    .ID_COUNT  (ID_COUNT),
    .MASK_BITS (MASK_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .entity_id_i    (entity_id_i),
    .mask_in_i      (mask_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .result_id_o    (result_id_o),
    .mask_out_o     (mask_out_o),
    .living_count_o (living_count_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

// ----- sim/entity_id_pool_with_masks_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the ID pool with per-ID component masks.
//
// A software copy of the pool (FIFO of free IDs, living list with a reverse
// index, mask per ID) predicts every result. Each accepted request is
// applied to that copy right away, and the predicted answer is queued. The
// result monitor pops the oldest answer for each accepted result and
// compares it field by field.
//
// Requests change at the falling edge; handshakes and results are sampled at
// the rising edge. Both sides idle at random. One pass holds off the result
// side long enough to back the block up into its request channel. Another
// pass stops sending until every queued answer has come back.

module entity_id_pool_with_masks_tb;
  import eip_pkg::*;

  localparam int unsigned ID_COUNT    = 128;
  localparam int unsigned MASK_BITS   = 32;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          PRINT_LIMIT = 40;
  // Mask bits that a set mask request keeps.
  localparam logic [MaskIoW-1:0] MASK_KEEP =
    (MASK_BITS >= MaskIoW) ? '1 : ((MaskIoW'(1) << MASK_BITS) - 1);

  typedef struct packed {
    logic                 ok;
    logic [ResultIdW-1:0] rid;
    logic [MaskIoW-1:0]   mask;
    logic [CountOutW-1:0] count;
  } pool_answer_t;

  // Drive every block input to a known value from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [ActionW-1:0]   action_i    = '0;
  logic [IdInW-1:0]     entity_id_i = '0;
  logic [MaskIoW-1:0]   mask_in_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 ok_o;
  logic [ResultIdW-1:0] result_id_o;
  logic [MaskIoW-1:0]   mask_out_o;
  logic [CountOutW-1:0] living_count_o;

  // Software copy of the pool state.
  logic [ResultIdW-1:0] free_ids  [ID_COUNT];
  int                   free_rd;
  int                   free_wr;
  logic [ResultIdW-1:0] live_ids  [ID_COUNT];
  int                   live_total;
  int                   live_slot [ID_COUNT];
  bit                   live_flag [ID_COUNT];
  logic [MaskIoW-1:0]   mask_mem  [ID_COUNT];

  pool_answer_t expected_answers[$];
  pool_answer_t oldest_answer;

  int errors      = 0;
  int cycle_count = 0;
  int stall_left  = 0;  // result-side stall drawn after each result
  int hold_cycles = 0;  // long result-side hold-off, counted down by the receiver
  bit no_idle     = 1'b0;

  entity_id_pool_with_masks #(
    .ID_COUNT  (ID_COUNT),
    .MASK_BITS (MASK_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .entity_id_i    (entity_id_i),
    .mask_in_i      (mask_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .result_id_o    (result_id_o),
    .mask_out_o     (mask_out_o),
    .living_count_o (living_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers pending",
               cycle_count, expected_answers.size());
      $display("entity_id_pool_with_masks_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  function automatic void reset_pool_copy();
    for (int i = 0; i < ID_COUNT; i++) begin
      free_ids[i]  = ResultIdW'(i);
      live_ids[i]  = '0;
      live_slot[i] = 0;
      live_flag[i] = 1'b0;
      mask_mem[i]  = '0;
    end
    free_rd    = 0;
    free_wr    = 0;
    live_total = 0;
  endfunction

  // Apply one request to the software pool and return the answer it owes.
  function automatic pool_answer_t pool_apply(action_e act, logic [IdInW-1:0] id,
                                              logic [MaskIoW-1:0] mask);
    pool_answer_t         ans;
    logic [ResultIdW-1:0] nid;
    logic [ResultIdW-1:0] moved;
    int                   slot;
    bit                   in_range;
    ans      = '0;
    in_range = (id < ID_COUNT);
    case (act)
      ACT_CREATE: begin
        // Pop the FIFO head unless every ID is in use.
        if (live_total < ID_COUNT) begin
          nid                  = free_ids[free_rd];
          free_rd              = (free_rd + 1) % ID_COUNT;
          live_ids[live_total] = nid;
          live_slot[nid]       = live_total;
          live_flag[nid]       = 1'b1;
          live_total++;
          ans.ok  = 1'b1;
          ans.rid = nid;
        end
      end
      ACT_DESTROY: begin
        // Ignore out-of-range IDs and an empty pool; otherwise clear the mask.
        if (in_range && live_total != 0) begin
          mask_mem[id] = '0;
          // Swap-remove a living ID and return it to the FIFO tail.
          if (live_flag[id]) begin
            slot               = live_slot[id];
            moved              = live_ids[live_total - 1];
            live_ids[slot]     = moved;
            live_slot[moved]   = slot;
            live_total--;
            live_flag[id]      = 1'b0;
            free_ids[free_wr]  = id[ResultIdW-1:0];
            free_wr            = (free_wr + 1) % ID_COUNT;
            ans.ok             = 1'b1;
          end
        end
      end
      ACT_SET_MASK: begin
        if (in_range) begin
          mask_mem[id] = mask & MASK_KEEP;
          ans.ok       = 1'b1;
        end
      end
      ACT_GET_MASK: begin
        if (in_range) begin
          ans.mask = mask_mem[id];
          ans.ok   = 1'b1;
        end
      end
      ACT_READ: begin
        if (id < live_total) begin
          ans.rid = live_ids[id];
          ans.ok  = 1'b1;
        end
      end
      default: ;
    endcase
    ans.count = CountOutW'(live_total);
    return ans;
  endfunction

  // Offer one request after a random gap, hold it until accepted, then
  // queue its predicted answer.
  task automatic send_request(action_e act, logic [IdInW-1:0] id, logic [MaskIoW-1:0] mask);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    entity_id_i <= id;
    mask_in_i   <= mask;
    do @(posedge clk_i); while (in_stall_o);
    expected_answers.insert(expected_answers.size(), pool_apply(act, id, mask));
  endtask

  // Drop valid and wait until every queued answer has come back.
  task automatic wait_for_answers();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
  endtask

  // Draw one request. Destroys mostly hit living IDs and reads mostly hit
  // valid slots, so the swap-remove and FIFO paths get real traffic.
  task automatic random_request(int create_pct, int destroy_pct);
    int                 pick;
    logic [IdInW-1:0]   id;
    logic [MaskIoW-1:0] mask;
    pick = $urandom_range(0, 99);
    id   = IdInW'($urandom_range(0, 255));
    mask = $urandom;
    if ($urandom_range(0, 7) == 0) mask = '0;
    else if ($urandom_range(0, 7) == 0) mask = '1;
    if (pick < create_pct) begin
      send_request(ACT_CREATE, id, mask);
    end else if (pick < create_pct + destroy_pct) begin
      if (live_total > 0 && $urandom_range(0, 7) != 0) begin
        id = IdInW'(live_ids[$urandom_range(0, live_total - 1)]);
      end
      send_request(ACT_DESTROY, id, mask);
    end else begin
      pick = $urandom_range(0, 2);
      if (pick == 2) begin
        if (live_total > 0 && $urandom_range(0, 5) != 0)
          id = IdInW'($urandom_range(0, live_total - 1));
        send_request(ACT_READ, id, mask);
      end else begin
        if ($urandom_range(0, 7) != 0) id = IdInW'($urandom_range(0, ID_COUNT - 1));
        send_request((pick == 0) ? ACT_SET_MASK : ACT_GET_MASK, id, mask);
      end
    end
  endtask

  // Walk the field extremes and every corner the pool has.
  task automatic test_directed_cases();
    // Destroy with no living IDs: ignored, so the mask survives.
    send_request(ACT_SET_MASK, 8'd5, 32'hA5A5_5A5A);
    send_request(ACT_DESTROY, 8'd5, '0);
    send_request(ACT_GET_MASK, 8'd5, '0);
    send_request(ACT_READ, 8'd0, '0);
    // Hand out IDs 0, 1, 2.
    repeat (3) send_request(ACT_CREATE, 8'hFF, 32'hFFFF_FFFF);
    send_request(ACT_SET_MASK, 8'd0, 32'hFFFF_FFFF);
    send_request(ACT_SET_MASK, 8'd127, 32'h0000_0001);
    send_request(ACT_SET_MASK, 8'd128, 32'h1234_5678);
    send_request(ACT_SET_MASK, 8'd255, 32'hFFFF_FFFF);
    send_request(ACT_GET_MASK, 8'd0, '0);
    send_request(ACT_GET_MASK, 8'd127, '0);
    send_request(ACT_GET_MASK, 8'd255, '0);
    send_request(ACT_READ, 8'd0, '0);
    send_request(ACT_READ, 8'd2, '0);
    send_request(ACT_READ, 8'd3, '0);
    // Remove the head of the list; the last entry moves into its slot.
    send_request(ACT_DESTROY, 8'd0, '0);
    send_request(ACT_READ, 8'd0, '0);
    // Destroy of a dead ID: clear the mask, leave the FIFO alone.
    send_request(ACT_DESTROY, 8'd0, '0);
    send_request(ACT_GET_MASK, 8'd0, '0);
    send_request(ACT_DESTROY, 8'd200, '0);
    send_request(ACT_DESTROY, 8'd5, '0);
    send_request(ACT_GET_MASK, 8'd5, '0);
    send_request(ACT_CREATE, 8'd0, '0);
    wait_for_answers();
  endtask

  // Fill the pool, fail creates against a full pool, then drain it fully.
  task automatic test_pool_exhaustion();
    while (live_total < ID_COUNT) begin
      if ($urandom_range(0, 3) == 0) random_request(0, 0);
      else send_request(ACT_CREATE, IdInW'($urandom_range(0, 255)), $urandom);
    end
    send_request(ACT_CREATE, 8'd0, '0);
    send_request(ACT_CREATE, 8'hFF, '1);
    send_request(ACT_READ, 8'd127, '0);
    send_request(ACT_READ, 8'd128, '0);
    while (live_total > 0) begin
      if ($urandom_range(0, 3) == 0) random_request(0, 0);
      else send_request(ACT_DESTROY, IdInW'(live_ids[$urandom_range(0, live_total - 1)]),
                        $urandom);
    end
    send_request(ACT_CREATE, 8'd0, '0);
    wait_for_answers();
  endtask

  // Alternate fill-heavy and drain-heavy stretches; one runs with no idling.
  task automatic test_random_traffic();
    int seg;
    for (seg = 0; seg < 4; seg++) begin
      no_idle = (seg == 2);
      repeat (200) begin
        if (seg % 2 == 0) random_request(65, 10);
        else random_request(8, 60);
      end
    end
    no_idle = 1'b0;
    wait_for_answers();
  endtask

  // Hold the result side off while requests keep coming, so the block backs
  // up and stalls its request channel.
  task automatic test_receiver_hold();
    hold_cycles = 250;
    repeat (30) random_request(40, 25);
    wait_for_answers();
  endtask

  // Stop sending until the block has answered everything, then resume.
  task automatic test_sender_pause();
    repeat (10) random_request(40, 25);
    wait_for_answers();
    repeat (10) random_request(40, 25);
    wait_for_answers();
  endtask

  // Result side: a long hold-off wins, else the stall drawn after the last result.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check each accepted result against the oldest queued answer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 9);
      if (expected_answers.size() == 0) begin
        report_mismatch("result with no request pending", 32'({ok_o, result_id_o}), '0);
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (ok_o !== oldest_answer.ok)
          report_mismatch("ok", 32'(ok_o), 32'(oldest_answer.ok));
        if (result_id_o !== oldest_answer.rid)
          report_mismatch("result_id", 32'(result_id_o), 32'(oldest_answer.rid));
        if (mask_out_o !== oldest_answer.mask)
          report_mismatch("mask_out", mask_out_o, oldest_answer.mask);
        if (living_count_o !== oldest_answer.count)
          report_mismatch("living_count", 32'(living_count_o), 32'(oldest_answer.count));
      end
    end
  end

  initial begin
    reset_pool_copy();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The block sweeps its tables after reset; send_request waits that out.
    test_directed_cases();
    test_pool_exhaustion();
    test_random_traffic();
    test_receiver_hold();
    test_sender_pause();
    // Give a stray late result time to show up.
    repeat (8) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      report_mismatch("answers never returned", '0, expected_answers.size());
    end
    if (errors == 0) begin
      $display("entity_id_pool_with_masks_tb: PASS");
    end else begin
      $display("entity_id_pool_with_masks_tb: FAIL");
    end
    $finish;
  end

endmodule
